// ----- hdl/rmf_pkg.sv -----
package rmf_pkg;

    localparam int CFG_ADDR_BITS = 2;
    localparam int CFG_DATA_BITS = 12;
    localparam int MSG_LEN_BITS  = 12;
    localparam int SEQ_BITS      = 5;
    localparam int QUEUE_DEPTH   = 2;
    localparam int QUEUE_AW      = 1;

    localparam logic [CFG_ADDR_BITS-1:0] CFG_FRAGMENT_SIZE    = 2'd0;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_REASSEMBLY_LIMIT = 2'd1;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_FRAGMENT_LIMIT   = 2'd2;

    localparam logic [7:0]  MIN_FRAGMENT           = 8'd64;
    localparam logic [7:0]  RST_FRAGMENT_SIZE      = 8'd180;
    localparam logic [11:0] RST_REASSEMBLY_LIMIT   = 12'd720;
    localparam logic [2:0]  RST_FRAGMENT_LIMIT     = 3'd4;

    typedef struct packed {
        logic [7:0]  fragment_size;
        logic [11:0] reassembly_limit;
        logic [2:0]  fragment_limit;
    } cfg_t;

    typedef struct packed {
        logic [MSG_LEN_BITS-1:0] length;
        logic                    fragmented;
        logic [SEQ_BITS-1:0]     seq;
        logic [SEQ_BITS-1:0]     next_seq;
    } desc_t;

endpackage

// ----- hdl/rmf_if.sv -----
interface rmf_msg_if;
    import rmf_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [MSG_LEN_BITS-1:0] message_length;
    modport source (output valid, output message_length, input ready);
    modport sink   (input valid, input message_length, output ready);
endinterface

interface rmf_res_if;
    logic        valid;
    logic        ready;
    logic [7:0]  flag_byte;
    logic [11:0] byte_offset;
    logic [7:0]  payload_length;
    logic        last_packet;
    logic [4:0]  next_sequence;
    modport source (output valid, output flag_byte, output byte_offset,
                    output payload_length, output last_packet, output next_sequence,
                    input ready);
    modport sink   (input valid, input flag_byte, input byte_offset,
                    input payload_length, input last_packet, input next_sequence,
                    output ready);
endinterface

interface rmf_cfg_if;
    import rmf_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [CFG_ADDR_BITS-1:0] addr;
    logic [CFG_DATA_BITS-1:0] data;
    modport source (output valid, output addr, output data, input ready);
    modport sink   (input valid, input addr, input data, output ready);
endinterface

// ----- hdl/rmf_front.sv -----
module rmf_front #(
    parameter int LENGTH_BITS = 12
) (
    input  logic           clk,
    input  logic           rst_n,
    rmf_msg_if.sink        msg_in,
    input  rmf_pkg::cfg_t  cfg_q,
    input  logic           full,
    output logic           push,
    output rmf_pkg::desc_t push_desc
);
    import rmf_pkg::*;

    localparam int LW = LENGTH_BITS + 1;
    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_COUNT = 1'b1;

    logic                   state_reg, state_next;
    logic [LENGTH_BITS-1:0] len_reg, len_next;
    logic [LENGTH_BITS-1:0] rem_reg, rem_next;
    logic [SEQ_BITS-1:0]    cnt_reg, cnt_next;
    logic [SEQ_BITS-1:0]    seq_reg, seq_next;

    logic [LENGTH_BITS-1:0] len_in;
    logic [11:0]            len_in12;
    logic [LW-1:0]          fs_w;
    logic                   accept;
    logic                   rem_last;

    assign len_in   = msg_in.message_length[LENGTH_BITS-1:0];
    assign len_in12 = 12'(len_in);
    assign fs_w     = LW'(cfg_q.fragment_size);
    assign rem_last = LW'(rem_reg) <= fs_w;

    assign msg_in.ready = (state_reg == ST_IDLE) && !full;
    assign accept       = msg_in.valid && msg_in.ready;

    always_comb
    begin
        state_next = state_reg;
        len_next   = len_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        seq_next   = seq_reg;
        push       = 1'b0;
        push_desc  = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && len_in12 != 12'd0)
                begin
                    if (len_in12 > cfg_q.reassembly_limit)
                    begin
                        len_next   = len_in;
                        rem_next   = len_in;
                        cnt_next   = '0;
                        state_next = ST_COUNT;
                    end
                    else
                    begin
                        push                 = 1'b1;
                        push_desc.length     = MSG_LEN_BITS'(len_in);
                        push_desc.fragmented = LW'(len_in) > fs_w;
                        push_desc.seq        = seq_reg;
                        push_desc.next_seq   = seq_reg + 5'd1;
                        seq_next             = seq_reg + 5'd1;
                    end
                end
            end
            ST_COUNT:
            begin
                if (rem_last)
                begin
                    if (!full)
                    begin
                        push                 = 1'b1;
                        push_desc.length     = MSG_LEN_BITS'(len_reg);
                        push_desc.fragmented = 1'b0;
                        push_desc.seq        = seq_reg;
                        push_desc.next_seq   = seq_reg + cnt_reg + 5'd1;
                        seq_next             = seq_reg + cnt_reg + 5'd1;
                        state_next           = ST_IDLE;
                    end
                end
                else
                begin
                    rem_next = LENGTH_BITS'(LW'(rem_reg) - fs_w);
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            seq_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            seq_reg   <= seq_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg <= len_next;
        rem_reg <= rem_next;
        cnt_reg <= cnt_next;
    end

endmodule

// ----- hdl/rmf_queue.sv -----
module rmf_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  rmf_pkg::desc_t push_desc,
    input  logic           pop,
    output rmf_pkg::desc_t pop_desc,
    output logic           full,
    output logic           empty
);
    import rmf_pkg::*;

    desc_t               slot_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]   count_reg, count_next;

    assign full     = count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH);
    assign empty    = count_reg == '0;
    assign pop_desc = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push && !full)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop && !empty)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        priority if ((push && !full) && !(pop && !empty))
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!(push && !full) && (pop && !empty))
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            slot_reg[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

// ----- hdl/rmf_back.sv -----
module rmf_back #(
    parameter int LENGTH_BITS = 12
) (
    input  logic           clk,
    input  logic           rst_n,
    input  rmf_pkg::cfg_t  cfg_q,
    input  logic           empty,
    input  rmf_pkg::desc_t pop_desc,
    output logic           pop,
    rmf_res_if.source      res_out
);
    import rmf_pkg::*;

    localparam int LW = LENGTH_BITS + 1;

    logic                   busy_reg, busy_next;
    logic                   term_reg, term_next;
    logic [LENGTH_BITS-1:0] off_reg, off_next;
    logic [1:0]             id_reg, id_next;
    logic [2:0]             cnt_reg, cnt_next;
    logic [SEQ_BITS-1:0]    seq_reg, seq_next;
    desc_t                  d_reg, d_next;

    logic                   ovalid_reg, ovalid_next;
    logic [7:0]             flag_reg, flag_next;
    logic [11:0]            boff_reg, boff_next;
    logic [7:0]             plen_reg, plen_next;
    logic                   last_reg, last_next;
    logic [SEQ_BITS-1:0]    nseq_reg, nseq_next;

    logic [LENGTH_BITS-1:0] len;
    logic [LENGTH_BITS-1:0] rem;
    logic [LW-1:0]          fs_w;
    logic                   emit;
    logic                   last_data;
    logic                   add_term;
    logic [2:0]             frag_num;

    assign len       = d_reg.length[LENGTH_BITS-1:0];
    assign rem       = len - off_reg;
    assign fs_w      = LW'(cfg_q.fragment_size);
    assign last_data = LW'(rem) <= fs_w;
    assign frag_num  = (cnt_reg == 3'd7) ? cnt_reg : cnt_reg + 3'd1;
    assign add_term  = d_reg.fragmented && (LW'(rem) == fs_w)
                       && (frag_num < cfg_q.fragment_limit);
    assign emit      = busy_reg && (!ovalid_reg || res_out.ready);
    assign pop       = !busy_reg && !empty;

    always_comb
    begin
        busy_next   = busy_reg;
        term_next   = term_reg;
        off_next    = off_reg;
        id_next     = id_reg;
        cnt_next    = cnt_reg;
        seq_next    = seq_reg;
        d_next      = d_reg;
        ovalid_next = ovalid_reg && !res_out.ready;
        flag_next   = flag_reg;
        boff_next   = boff_reg;
        plen_next   = plen_reg;
        last_next   = last_reg;
        nseq_next   = nseq_reg;
        if (pop)
        begin
            busy_next = 1'b1;
            term_next = 1'b0;
            off_next  = '0;
            id_next   = '0;
            cnt_next  = '0;
            seq_next  = pop_desc.seq;
            d_next    = pop_desc;
        end
        else if (emit)
        begin
            ovalid_next = 1'b1;
            nseq_next   = d_reg.next_seq;
            if (term_reg)
            begin
                flag_next = {seq_reg, id_reg, 1'b1};
                boff_next = 12'(len);
                plen_next = '0;
                last_next = 1'b1;
                busy_next = 1'b0;
            end
            else
            begin
                flag_next = d_reg.fragmented ? {seq_reg, id_reg, 1'b1}
                                             : {seq_reg, 3'b000};
                boff_next = 12'(off_reg);
                plen_next = last_data ? rem[7:0] : cfg_q.fragment_size;
                last_next = last_data && !add_term;
                id_next   = id_reg + 2'd1;
                cnt_next  = frag_num;
                if (!d_reg.fragmented)
                begin
                    seq_next = seq_reg + 5'd1;
                end
                if (last_data)
                begin
                    if (add_term)
                    begin
                        term_next = 1'b1;
                    end
                    else
                    begin
                        busy_next = 1'b0;
                    end
                end
                else
                begin
                    off_next = LENGTH_BITS'(LW'(off_reg) + fs_w);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            busy_reg   <= busy_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        term_reg <= term_next;
        off_reg  <= off_next;
        id_reg   <= id_next;
        cnt_reg  <= cnt_next;
        seq_reg  <= seq_next;
        d_reg    <= d_next;
        flag_reg <= flag_next;
        boff_reg <= boff_next;
        plen_reg <= plen_next;
        last_reg <= last_next;
        nseq_reg <= nseq_next;
    end

    assign res_out.valid          = ovalid_reg;
    assign res_out.flag_byte      = flag_reg;
    assign res_out.byte_offset    = boff_reg;
    assign res_out.payload_length = plen_reg;
    assign res_out.last_packet    = last_reg;
    assign res_out.next_sequence  = nseq_reg;

endmodule

// ----- hdl/rtcm_message_fragmenter.sv -----
// channel   modport  payload
// msg_in    sink     message_length
// res_out   source   flag_byte, byte_offset, payload_length, last_packet, next_sequence
// cfg       sink     addr (register index), data
//
// Front: accepts a message while idle and the queue is not full; messages over the
// reassembly limit are counted into fragments by repeated subtraction before the push.
// Back: loads a descriptor while idle, then emits its packets through the output register.
// A 2-entry descriptor queue separates the two; res_out stalls reach the front once it fills.
// rst_n clears control state and the sequence counter; config resets to its defaults.
module rtcm_message_fragmenter #(
    parameter int LENGTH_BITS = 12
) (
    input  logic      clk,
    input  logic      rst_n,
    rmf_msg_if.sink   msg_in,
    rmf_res_if.source res_out,
    rmf_cfg_if.sink   cfg
);
    import rmf_pkg::*;

    logic [7:0]  fsize_reg;
    logic [11:0] rlimit_reg;
    logic [2:0]  flimit_reg;
    cfg_t        cfg_q;
    logic        push;
    logic        pop;
    logic        full;
    logic        empty;
    desc_t       push_desc;
    desc_t       pop_desc;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsize_reg  <= RST_FRAGMENT_SIZE;
            rlimit_reg <= RST_REASSEMBLY_LIMIT;
            flimit_reg <= RST_FRAGMENT_LIMIT;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.addr)
                CFG_FRAGMENT_SIZE:    fsize_reg  <= cfg.data[7:0];
                CFG_REASSEMBLY_LIMIT: rlimit_reg <= cfg.data[11:0];
                CFG_FRAGMENT_LIMIT:   flimit_reg <= cfg.data[2:0];
                default:              ;
            endcase
        end
    end

    assign cfg_q.fragment_size    = (fsize_reg < MIN_FRAGMENT) ? MIN_FRAGMENT : fsize_reg;
    assign cfg_q.reassembly_limit = rlimit_reg;
    assign cfg_q.fragment_limit   = flimit_reg;

    rmf_front #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .msg_in    (msg_in),
        .cfg_q     (cfg_q),
        .full      (full),
        .push      (push),
        .push_desc (push_desc)
    );

    rmf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .pop       (pop),
        .pop_desc  (pop_desc),
        .full      (full),
        .empty     (empty)
    );

    rmf_back #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_q    (cfg_q),
        .empty    (empty),
        .pop_desc (pop_desc),
        .pop      (pop),
        .res_out  (res_out)
    );

`ifndef ASSERT_OFF
    a_unfrag_no_id: assert property (@(posedge clk) disable iff (!rst_n)
        res_out.valid |-> (res_out.flag_byte[0] || res_out.flag_byte[2:1] == 2'b00))
        else $error("unfragmented packet carries a fragment id");

    a_term_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (res_out.valid && res_out.payload_length == 8'd0)
        |-> (res_out.flag_byte[0] && res_out.last_packet))
        else $error("empty packet is not a final fragment");

    a_full_middle: assert property (@(posedge clk) disable iff (!rst_n)
        (res_out.valid && !res_out.last_packet)
        |-> (res_out.payload_length == cfg_q.fragment_size))
        else $error("non-final packet is not full size");

    a_unfrag_seq: assert property (@(posedge clk) disable iff (!rst_n)
        (res_out.valid && res_out.last_packet && !res_out.flag_byte[0])
        |-> (res_out.next_sequence == res_out.flag_byte[7:3] + 5'd1))
        else $error("final unfragmented packet sequence mismatch");
`endif

endmodule

// ----- sim/rtcm_message_fragmenter_test.sv -----
`timescale 1ns / 100ps

module rtcm_message_fragmenter_test;
    import rmf_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 80;
    localparam int HOLD_CYCLES   = 400;
    localparam int RANDOM_ITEMS  = 12;
    localparam int MAX_REPORTS   = 40;

    typedef struct packed {
        logic [7:0]  flags;
        logic [11:0] offset;
        logic [7:0]  plen;
        logic        last;
        logic [4:0]  nseq;
    } pkt_desc_t;

    typedef enum logic [1:0] {RX_STREAM, RX_COIN, RX_SPARSE, RX_PULSE} rx_mode_e;

    logic clk = 1'b0;
    logic rst_n;

    rmf_msg_if msg_if ();
    rmf_res_if res_if ();
    rmf_cfg_if cfg_if ();

    rtcm_message_fragmenter i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .msg_in  (msg_if),
        .res_out (res_if),
        .cfg     (cfg_if)
    );

    always #2 clk = ~clk;

    // predictor state
    logic [7:0]  frag_size_reg;
    logic [11:0] reasm_limit_reg;
    logic [2:0]  frag_limit_reg;
    logic [4:0]  seq_no;

    logic [11:0] pending_lengths[$];
    pkt_desc_t   expected_packets[$];

    int mismatches      = 0;
    int messages_taken  = 0;
    int empty_messages  = 0;
    int split_messages  = 0;
    int group_messages  = 0;
    int terminators     = 0;
    int packets_checked = 0;
    int config_sets     = 0;
    int cycle_count     = 0;

    int       gap_left    = 0;
    int       burst_left  = 0;
    int       hold_left   = 0;
    bit       hold_request = 1'b0;
    bit       draining     = 1'b0;
    rx_mode_e stall_mode   = RX_STREAM;
    int       mode_left    = 0;

    function automatic logic [7:0] flag_bits(input bit fragmented, input int unsigned id,
                                             input logic [4:0] seq);
        return {seq, fragmented ? id[1:0] : 2'b00, fragmented};
    endfunction

    function automatic void add_packet(input logic [7:0] flags, input int unsigned off,
                                       input int unsigned len, input bit last,
                                       input logic [4:0] nseq);
        pkt_desc_t d;
        d.flags  = flags;
        d.offset = off[11:0];
        d.plen   = len[7:0];
        d.last   = last;
        d.nseq   = nseq;
        expected_packets.push_back(d);
    endfunction

    function automatic void predict_packets(input logic [11:0] length);
        int unsigned n, fs, count, off, pl, id;
        logic [4:0]  seq, nxt;
        bit          term;
        n  = 32'(length);
        fs = 32'((frag_size_reg < MIN_FRAGMENT) ? MIN_FRAGMENT : frag_size_reg);
        messages_taken++;
        if (n == 0) begin
            empty_messages++;
            return;
        end
        count = (n + fs - 1) / fs;
        seq   = seq_no;
        if (n > reasm_limit_reg) begin
            split_messages++;
            nxt = seq_no + count[4:0];
            for (off = 0; off < n; off += fs) begin
                pl = (n - off < fs) ? n - off : fs;
                add_packet(flag_bits(1'b0, 0, seq), off, pl, off + fs >= n, nxt);
                seq = seq + 5'd1;
            end
        end else begin
            nxt = seq_no + 5'd1;
            if (n <= fs) begin
                add_packet(flag_bits(1'b0, 0, seq), 0, n, 1'b1, nxt);
            end else begin
                group_messages++;
                term = (n % fs == 0) && (count < frag_limit_reg);
                id   = 0;
                for (off = 0; off < n; off += fs) begin
                    pl = (n - off < fs) ? n - off : fs;
                    add_packet(flag_bits(1'b1, id, seq), off, pl, (off + fs >= n) && !term, nxt);
                    id++;
                end
                if (term) begin
                    terminators++;
                    add_packet(flag_bits(1'b1, id, seq), n, 0, 1'b1, nxt);
                end
            end
        end
        seq_no = nxt;
    endfunction

    function automatic logic [11:0] random_length();
        int unsigned fs, lim, v, top;
        fs  = 32'((frag_size_reg < MIN_FRAGMENT) ? MIN_FRAGMENT : frag_size_reg);
        lim = 32'(reasm_limit_reg);
        case ($urandom_range(0, 9))
            0: v = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4095);
            1, 2: v = $urandom_range(1, fs);
            3, 4: v = (lim > fs) ? $urandom_range(fs + 1, lim) : $urandom_range(1, 4095);
            5, 6: v = fs * $urandom_range(1, 6);
            7: begin
                top = (lim + 4 * fs > 4095) ? 4095 : lim + 4 * fs;
                v = (lim < 4095) ? $urandom_range(lim + 1, top) : $urandom_range(0, 4095);
            end
            8: v = $urandom_range(0, 4095);
            default: v = fs * $urandom_range(1, 4) + $urandom_range(0, 2) - 1;
        endcase
        return (v > 4095) ? 12'd4095 : v[11:0];
    endfunction

    // sender: bursts with random gaps
    always @(posedge clk) begin
        if (!rst_n) begin
            msg_if.valid <= 1'b0;
        end else if (!msg_if.valid || msg_if.ready) begin
            if (gap_left != 0) begin
                gap_left     <= gap_left - 1;
                msg_if.valid <= 1'b0;
            end else if (pending_lengths.size() != 0) begin
                msg_if.valid          <= 1'b1;
                msg_if.message_length <= pending_lengths.pop_front();
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                msg_if.valid <= 1'b0;
            end
        end
    end

    // long output hold-off
    always @(posedge clk) begin
        if (hold_request && hold_left == 0) begin
            hold_left    <= HOLD_CYCLES;
            hold_request = 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // receiver stall pattern
    always @(posedge clk) begin
        if (mode_left == 0) begin
            stall_mode <= rx_mode_e'($urandom_range(0, 3));
            mode_left  <= $urandom_range(20, 120);
        end else begin
            mode_left <= mode_left - 1;
        end
        if (draining) begin
            res_if.ready <= 1'b1;
        end else if (hold_left != 0) begin
            res_if.ready <= 1'b0;
        end else begin
            case (stall_mode)
                RX_STREAM: res_if.ready <= 1'b1;
                RX_COIN:   res_if.ready <= 1'($urandom_range(0, 1));
                RX_SPARSE: res_if.ready <= ($urandom_range(0, 3) == 0);
                RX_PULSE:  res_if.ready <= cycle_count[1];
            endcase
        end
    end

    // input monitor
    always @(posedge clk) begin
        if (rst_n && msg_if.valid && msg_if.ready)
            predict_packets(msg_if.message_length);
    end

    task automatic check_field(input string field, input logic [11:0] want,
                               input logic [11:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: %s expected 0x%0h, got 0x%0h", $time, field, want, got);
        end
    endtask

    // output monitor
    always @(posedge clk) begin
        pkt_desc_t want;
        if (rst_n && res_if.valid && res_if.ready) begin
            if (expected_packets.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected transaction, expected none, got flags 0x%0h",
                             $time, res_if.flag_byte);
            end else begin
                want = expected_packets.pop_front();
                check_field("flag_byte", 12'(want.flags), 12'(res_if.flag_byte));
                check_field("byte_offset", want.offset, res_if.byte_offset);
                check_field("payload_length", 12'(want.plen), 12'(res_if.payload_length));
                check_field("last_packet", 12'(want.last), 12'(res_if.last_packet));
                check_field("next_sequence", 12'(want.nseq), 12'(res_if.next_sequence));
                packets_checked++;
            end
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d transactions still expected", $time,
                     expected_packets.size());
            $display("FAIL");
            $finish;
        end
    end

    task automatic put_reg(input logic [CFG_ADDR_BITS-1:0] index, input logic [11:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.addr  <= index;
        cfg_if.data  <= value;
        do @(posedge clk); while (!cfg_if.ready);
        case (index)
            CFG_FRAGMENT_SIZE:    frag_size_reg   = value[7:0];
            CFG_REASSEMBLY_LIMIT: reasm_limit_reg = value;
            CFG_FRAGMENT_LIMIT:   frag_limit_reg  = value[2:0];
            default: ;
        endcase
    endtask

    task automatic write_config(input logic [11:0] fs, input logic [11:0] lim,
                                input logic [11:0] flim);
        @(posedge clk);
        put_reg(CFG_FRAGMENT_SIZE, fs);
        put_reg(CFG_REASSEMBLY_LIMIT, lim);
        put_reg(CFG_FRAGMENT_LIMIT, flim);
        cfg_if.valid <= 1'b0;
        config_sets++;
        @(negedge clk);
    endtask

    task automatic wait_idle();
        do @(posedge clk);
        while (pending_lengths.size() != 0 || msg_if.valid || expected_packets.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic add_random(input bit with_hold);
        for (int i = 0; i < RANDOM_ITEMS; i++)
            pending_lengths.push_back(random_length());
        if (with_hold)
            hold_request = 1'b1;
    endtask

    initial begin
        rst_n                 = 1'b0;
        msg_if.valid          = 1'b0;
        msg_if.message_length = '0;
        res_if.ready          = 1'b0;
        cfg_if.valid          = 1'b0;
        cfg_if.addr           = '0;
        cfg_if.data           = '0;
        frag_size_reg         = RST_FRAGMENT_SIZE;
        reasm_limit_reg       = RST_REASSEMBLY_LIMIT;
        frag_limit_reg        = RST_FRAGMENT_LIMIT;
        seq_no                = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset defaults
        pending_lengths = '{12'd1, 12'd180, 12'd181, 12'd360, 12'd720, 12'd721,
                            12'd4095, 12'd0};
        add_random(1'b0);
        wait_idle();

        // smallest fragment, everything reassemblable, fragment id wraps
        write_config(12'd64, 12'd4095, 12'd4);
        pending_lengths = '{12'd4095, 12'd256, 12'd192, 12'd64};
        add_random(1'b1);
        wait_idle();

        // zero fragment size and limits: every non-empty message split, no terminator
        write_config(12'd0, 12'd0, 12'd0);
        pending_lengths = '{12'd1, 12'd64, 12'd65};
        add_random(1'b0);
        wait_idle();

        write_config(12'd255, 12'd64, 12'd1);
        pending_lengths = '{12'd255, 12'd510, 12'd64};
        add_random(1'b0);
        wait_idle();

        write_config(12'd63, 12'd1000, 12'd7);
        pending_lengths = '{12'd960, 12'd384, 12'd1000};
        add_random(1'b0);
        wait_idle();

        // unused upper data bits set
        write_config(12'hF64, 12'd300, 12'h00B);
        pending_lengths = '{12'd200, 12'd300};
        add_random(1'b1);
        wait_idle();

        write_config(12'd128, 12'd2048, 12'd2);
        pending_lengths = '{12'd128, 12'd256, 12'd2048};
        add_random(1'b0);
        wait_idle();

        write_config(12'(RST_FRAGMENT_SIZE), RST_REASSEMBLY_LIMIT, 12'(RST_FRAGMENT_LIMIT));
        add_random(1'b0);
        wait_idle();

        @(negedge clk);
        draining = 1'b1;
        repeat (100) @(posedge clk);

        $display("%0d messages over %0d register settings: %0d empty, %0d split, %0d grouped",
                 messages_taken, config_sets + 1, empty_messages, split_messages,
                 group_messages);
        $display("%0d descriptors checked, %0d terminators, two long output hold-offs",
                 packets_checked, terminators);
        if (mismatches == 0 && expected_packets.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
